/* rtl/core/lss_pkg.sv */
// Shared constants, codes and control structs of the Laplacian stencil stream.
`default_nettype none

package lss_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int WIDTH_BITS     = 12;
  localparam int HEIGHT_BITS    = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // What one issued request does in the compute stage.
  typedef struct packed {
    logic store;      // first row: write both lines, no result
    logic emit;       // produce a result
    logic write_mid;  // request carries a pixel for the middle line
    logic use_right;  // right neighbour lies inside the row
    logic last;       // final result of the frame
  } op_t;

  // Read ports that must take the value written in the same cycle.
  typedef struct packed {
    logic up;
    logic mid_c;
    logic mid_r;
  } fwd_t;

  typedef struct packed {
    logic up_we;
    logic mid_we;
  } line_we_t;

endpackage

`default_nettype wire

/* rtl/core/laplacian_stencil_stream.sv */
// Top level of the streaming 5-point Laplacian with replicated borders.
// One request per clock in both directions unless the output stalls: a pixel or flush
// request is taken every cycle, and the result of pixel (r,c) passes the stage and
// output registers after pixel (r+1,c) is taken, or after the flush request that
// drains column c of the last row. The rate is set by the two line memories (upper
// and middle, MAX_WIDTH x PIXEL_BITS each): each request reads both in the cycle it
// is taken and writes them back as it leaves the stage, with the just-written entry
// forwarded when the following request reads it. Row 0 is only stored; after the
// last row, frame_width flush requests drain it, the final one flagged with
// out_tlast. Extra flushes and pixels sent while draining are taken and dropped.
// Write frame_width and frame_height only while no request is in flight.
`default_nettype none

module laplacian_stencil_stream #(
  parameter int MAX_WIDTH  = lss_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lss_pkg::PIXEL_BITS_DEF,
  localparam int LW          = PIXEL_BITS + 3,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((LW + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [IN_TDATA_W-1:0]              in_tdata,   // pixel
  input  wire logic [0:0]                         in_tuser,   // cmd
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [OUT_TDATA_W-1:0]                  out_tdata,  // laplacian
  output logic                                    out_tlast
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                         slot_free, issue_valid;
  lss_pkg::op_t                 issue_op;
  logic [AW-1:0]                issue_col, wr_col;
  logic signed [PIXEL_BITS-1:0] issue_pixel;
  lss_pkg::line_we_t            wr;
  logic signed [PIXEL_BITS-1:0] up_wdata, mid_wdata;
  logic signed [PIXEL_BITS-1:0] up_rdata, mid_c_rdata, mid_r_rdata;
  logic signed [LW-1:0]         lap;

  assign issue_pixel = $signed(in_tdata[PIXEL_BITS-1:0]);

  lss_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_cmd      (in_tuser[0]),
    .slot_free   (slot_free),
    .in_ready    (in_tready),
    .issue_valid (issue_valid),
    .issue_op    (issue_op),
    .issue_col   (issue_col)
  );

  lss_lines #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_lines (
    .clk         (clk),
    .rd_en       (issue_valid),
    .rd_col      (issue_col),
    .wr          (wr),
    .wr_col      (wr_col),
    .up_wdata    (up_wdata),
    .mid_wdata   (mid_wdata),
    .up_rdata    (up_rdata),
    .mid_c_rdata (mid_c_rdata),
    .mid_r_rdata (mid_r_rdata)
  );

  lss_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_op    (issue_op),
    .issue_col   (issue_col),
    .issue_pixel (issue_pixel),
    .slot_free   (slot_free),
    .up_rdata    (up_rdata),
    .mid_c_rdata (mid_c_rdata),
    .mid_r_rdata (mid_r_rdata),
    .wr          (wr),
    .wr_col      (wr_col),
    .up_wdata    (up_wdata),
    .mid_wdata   (mid_wdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_lap     (lap),
    .out_last    (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'($unsigned(lap));

endmodule

`default_nettype wire

/* rtl/core/lss_seq.sv */
// Column, row and drain sequencing plus the configuration registers.
`default_nettype none

module lss_seq #(
  parameter int MAX_WIDTH = lss_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [lss_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_cmd,
  input  wire logic                                 slot_free,
  output logic                                      in_ready,
  output logic                                      issue_valid,
  output lss_pkg::op_t                              issue_op,
  output logic [AW-1:0]                             issue_col
);

  localparam int CW = AW + 1;
  localparam int WW = (CW > lss_pkg::WIDTH_BITS) ? CW : lss_pkg::WIDTH_BITS;
  localparam int HW = lss_pkg::HEIGHT_BITS + 1;

  logic [lss_pkg::WIDTH_BITS-1:0]  frame_width_r;
  logic [lss_pkg::HEIGHT_BITS-1:0] frame_height_r;
  logic [AW-1:0]                   col_r, col_nxt;
  logic [lss_pkg::HEIGHT_BITS-1:0] row_r, row_nxt;
  logic                            draining_r, draining_nxt;

  logic [WW-1:0] fw_ext, w_sat;
  logic [CW-1:0] w, col_inc;
  logic [HW-1:0] h, row_inc;
  logic          row_end, frame_end, flush, take, acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = slot_free;
  assign acc       = in_valid && slot_free;
  assign flush     = (lss_pkg::cmd_t'(in_cmd) == lss_pkg::CMD_FLUSH);

  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (fw_ext == '0) begin
      w_sat = WW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = fw_ext;
    end
  end

  assign w         = w_sat[CW-1:0];
  assign h         = (frame_height_r == '0) ? HW'(1) : HW'(frame_height_r);
  assign col_inc   = CW'(col_r) + CW'(1);
  assign row_inc   = HW'(row_r) + HW'(1);
  assign row_end   = (col_inc >= w);
  assign frame_end = (row_inc >= h);
  assign issue_col = col_r;

  always_comb begin
    issue_op     = '0;
    take         = 1'b0;
    col_nxt      = col_r;
    row_nxt      = row_r;
    draining_nxt = draining_r;
    if (draining_r) begin
      // drain the last row, one flush per column; pixels are dropped
      if (flush) begin
        take               = 1'b1;
        issue_op.emit      = 1'b1;
        issue_op.use_right = !row_end;
        issue_op.last      = row_end;
        if (row_end) begin
          col_nxt      = '0;
          row_nxt      = '0;
          draining_nxt = 1'b0;
        end else begin
          col_nxt = col_inc[AW-1:0];
        end
      end
    end else if (!flush) begin
      take               = 1'b1;
      issue_op.write_mid = 1'b1;
      issue_op.use_right = !row_end;
      if (row_r == '0) begin
        issue_op.store = 1'b1;
      end else begin
        issue_op.emit = 1'b1;
      end
      if (row_end) begin
        col_nxt = '0;
        if (frame_end) begin
          draining_nxt = 1'b1;
        end else begin
          row_nxt = row_inc[lss_pkg::HEIGHT_BITS-1:0];
        end
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end
  end

  assign issue_valid = acc && take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      draining_r <= 1'b0;
    end else if (issue_valid) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      draining_r <= draining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lss_pkg::FRAME_WIDTH_RST;
      frame_height_r <= lss_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (lss_pkg::reg_index_t'(cfg_index))
        lss_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[lss_pkg::WIDTH_BITS-1:0];
        lss_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lss_lines.sv */
// Upper and middle line memories with registered read ports.
`default_nettype none

module lss_lines #(
  parameter int MAX_WIDTH  = lss_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lss_pkg::PIXEL_BITS_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_col,
  input  wire lss_pkg::line_we_t            wr,
  input  wire logic [AW-1:0]                wr_col,
  input  wire logic signed [PIXEL_BITS-1:0] up_wdata,
  input  wire logic signed [PIXEL_BITS-1:0] mid_wdata,
  output logic signed [PIXEL_BITS-1:0]      up_rdata,
  output logic signed [PIXEL_BITS-1:0]      mid_c_rdata,
  output logic signed [PIXEL_BITS-1:0]      mid_r_rdata
);

  logic signed [PIXEL_BITS-1:0] up_mem  [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] up_rd_r, mid_c_rd_r, mid_r_rd_r;
  logic [AW-1:0]                rd_col_next;

  assign rd_col_next = rd_col + AW'(1);

  always_ff @(posedge clk) begin
    if (wr.up_we) begin
      up_mem[wr_col] <= up_wdata;
    end
    if (wr.mid_we) begin
      mid_mem[wr_col] <= mid_wdata;
    end
  end

  // hold read data until the next request is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rd_r    <= up_mem[rd_col];
      mid_c_rd_r <= mid_mem[rd_col];
      mid_r_rd_r <= mid_mem[rd_col_next];
    end
  end

  assign up_rdata    = up_rd_r;
  assign mid_c_rdata = mid_c_rd_r;
  assign mid_r_rdata = mid_r_rd_r;

endmodule

`default_nettype wire

/* rtl/core/lss_stage.sv */
// Compute stage: forwarding, stencil sum, line write-back and output register.
`default_nettype none

module lss_stage #(
  parameter int MAX_WIDTH  = lss_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lss_pkg::PIXEL_BITS_DEF,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int LW = PIXEL_BITS + 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         issue_valid,
  input  wire lss_pkg::op_t                 issue_op,
  input  wire logic [AW-1:0]                issue_col,
  input  wire logic signed [PIXEL_BITS-1:0] issue_pixel,
  output logic                              slot_free,
  input  wire logic signed [PIXEL_BITS-1:0] up_rdata,
  input  wire logic signed [PIXEL_BITS-1:0] mid_c_rdata,
  input  wire logic signed [PIXEL_BITS-1:0] mid_r_rdata,
  output lss_pkg::line_we_t                 wr,
  output logic [AW-1:0]                     wr_col,
  output logic signed [PIXEL_BITS-1:0]      up_wdata,
  output logic signed [PIXEL_BITS-1:0]      mid_wdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [LW-1:0]              out_lap,
  output logic                              out_last
);

  logic                         s1_valid_r;
  lss_pkg::op_t                 s1_op_r;
  logic [AW-1:0]                s1_col_r;
  logic signed [PIXEL_BITS-1:0] s1_pix_r;
  lss_pkg::fwd_t                fwd_r, fwd_nxt;
  logic signed [PIXEL_BITS-1:0] fwd_up_r, fwd_mid_r;
  logic signed [PIXEL_BITS-1:0] left_r;
  logic                         out_valid_r, out_last_r;
  logic signed [LW-1:0]         out_lap_r;

  logic signed [PIXEL_BITS-1:0] centre, up, right, left, down;
  logic signed [LW-1:0]         lap;
  logic                         s1_adv;

  // the write of the previous request lands in the same cycle as this read
  assign centre = fwd_r.mid_c ? fwd_mid_r : mid_c_rdata;
  assign up     = fwd_r.up ? fwd_up_r : up_rdata;
  assign right  = !s1_op_r.use_right ? centre : (fwd_r.mid_r ? fwd_mid_r : mid_r_rdata);
  assign left   = (s1_col_r == '0) ? centre : left_r;
  assign down   = s1_op_r.write_mid ? s1_pix_r : centre;

  assign lap = (LW'(centre) <<< 2) - LW'(up) - LW'(down) - LW'(left) - LW'(right);

  assign s1_adv    = s1_valid_r && (!s1_op_r.emit || !out_valid_r || out_ready);
  assign slot_free = !s1_valid_r || s1_adv;

  assign wr.up_we  = s1_adv;
  assign wr.mid_we = s1_adv && s1_op_r.write_mid;
  assign wr_col    = s1_col_r;
  assign up_wdata  = s1_op_r.store ? s1_pix_r : centre;
  assign mid_wdata = s1_pix_r;

  always_comb begin
    fwd_nxt.up    = s1_valid_r && (s1_col_r == issue_col);
    fwd_nxt.mid_c = s1_valid_r && s1_op_r.write_mid && (s1_col_r == issue_col);
    fwd_nxt.mid_r = s1_valid_r && s1_op_r.write_mid && (s1_col_r == issue_col + AW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue_valid) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_valid) begin
      s1_op_r   <= issue_op;
      s1_col_r  <= issue_col;
      s1_pix_r  <= issue_pixel;
      fwd_r     <= fwd_nxt;
      fwd_up_r  <= up_wdata;
      fwd_mid_r <= mid_wdata;
    end
    if (s1_adv) begin
      left_r <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_op_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_op_r.emit) begin
      out_lap_r  <= lap;
      out_last_r <= s1_op_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lap   = out_lap_r;
  assign out_last  = out_last_r;

  a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
    issue_valid |-> slot_free)
    else $error("request issued while the compute stage is occupied");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_op_r.emit && out_valid_r && !out_ready) |=>
    (s1_valid_r && $stable(s1_col_r)))
    else $error("stalled request left the compute stage");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_op_r.emit))
    else $error("result appeared without an emitting request");

  a_no_lost_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_op_r.emit) |=> !(s1_valid_r && $stable(s1_col_r) && $stable(s1_op_r)
                                       && !$past(issue_valid) && $past(s1_valid_r)))
    else $error("store request did not retire");

endmodule

`default_nettype wire
